// File: rtl/barometric_pressure_compensation_assert.svh
// Assertion macros shared by the barometric pressure compensation RTL.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked at every rising edge of clk, suspended while rst is high.
`define BPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every rising edge of clk, reset included.
`define BPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BPC_ASSERT(lbl, prop, msg)
`define BPC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/bpc_pkg.sv
// Types, constants and helper functions for the barometric pressure compensation block.
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

  // Input and result payloads.
  typedef struct packed {
    logic        kind;
    logic [23:0] raw_value;
  } in_t;

  typedef struct packed {
    logic [17:0] pressure_pa;
    logic        div_fault;
  } out_t;

  // Calibration and oversampling settings.
  typedef struct packed {
    logic [31:0] ac1_ac2;
    logic [31:0] ac3_ac4;
    logic [31:0] ac5_ac6;
    logic [31:0] b1_b2;
    logic [31:0] mc_md;
    logic [1:0]  oss;
  } cal_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_AC1_AC2 = 3'd0;
  localparam logic [2:0] REG_AC3_AC4 = 3'd1;
  localparam logic [2:0] REG_AC5_AC6 = 3'd2;
  localparam logic [2:0] REG_B1_B2   = 3'd3;
  localparam logic [2:0] REG_MC_MD   = 3'd4;
  localparam logic [2:0] REG_OSS     = 3'd5;

  // Input kinds.
  localparam logic KIND_TEMP  = 1'b0;
  localparam logic KIND_PRESS = 1'b1;

  // Compensation constants.
  localparam logic [31:0] C_B6_OFS  = 32'd4000;
  localparam logic [31:0] C_B4_RND  = 32'd32768;
  localparam logic [31:0] C_B7_K    = 32'd50000;
  localparam logic [31:0] C_K1      = 32'd3038;
  localparam logic [31:0] C_K2      = 32'hFFFF_E343;
  localparam logic [31:0] C_K3      = 32'd3791;
  localparam logic [31:0] C_P_MAX   = 32'd262143;
  localparam logic [1:0]  OSS_RESET = 2'd3;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL_T, ST_CHK_DEN, ST_WAIT_D1, ST_MUL_SQ, ST_MUL_B2,
    ST_MUL_A2, ST_MUL_A3, ST_MUL_B1, ST_MUL_A4, ST_MUL_B7, ST_CHK_B7,
    ST_WAIT_D2, ST_MUL_PP, ST_MUL_K1, ST_MUL_K2, ST_FIN, ST_DONE
  } state_t;

  // Sign extension of a 16-bit calibration field.
  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  // Arithmetic right shift of a 32-bit word.
  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
    asr = $unsigned($signed(v) >>> n);
  endfunction

endpackage
`default_nettype wire

// File: rtl/barometric_pressure_compensation.sv
// Top level of the barometric pressure compensation block.
`timescale 1ns / 1ps
`default_nettype none
`include "barometric_pressure_compensation_assert.svh"
// A temperature transaction stores the raw 16-bit temperature, gives no result and
// leaves in_stall low. A pressure transaction holds in_stall high while its result is
// computed from two divisions in the bit-serial divider, eleven passes through the
// shared 32x32 multiplier and a few control steps. A zero divisor in the temperature
// term or in the pressure term ends the computation early with the fault result.
// The result then moves to the output register, so the next transaction can be taken
// while it waits there; if that register is still held by out_stall, the finished
// result waits in the sequencer and in_stall stays high until it can move.
// Calibration is written through cfg_we, cfg_index and cfg_wdata; the user must do so
// only while the block is idle, as the block itself does not enforce this.
module barometric_pressure_compensation (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire bpc_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output bpc_pkg::out_t       out_data,
  input  wire logic           cfg_we,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [31:0]    cfg_wdata
);

  bpc_pkg::cal_t cal;
  bpc_pkg::out_t res;
  logic [15:0]   last_t;
  logic          in_acc, core_start, busy, res_valid, res_take;

  assign in_stall   = busy;
  assign in_acc     = in_valid && !in_stall;
  assign core_start = in_acc && (in_data.kind == bpc_pkg::KIND_PRESS);
  assign res_take   = res_valid && (!out_valid || !out_stall);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '{ac1_ac2: '0, ac3_ac4: '0, ac5_ac6: '0, b1_b2: '0, mc_md: '0,
               oss: bpc_pkg::OSS_RESET};
    end else if (cfg_we) begin
      case (cfg_index)
        bpc_pkg::REG_AC1_AC2: cal.ac1_ac2 <= cfg_wdata;
        bpc_pkg::REG_AC3_AC4: cal.ac3_ac4 <= cfg_wdata;
        bpc_pkg::REG_AC5_AC6: cal.ac5_ac6 <= cfg_wdata;
        bpc_pkg::REG_B1_B2:   cal.b1_b2   <= cfg_wdata;
        bpc_pkg::REG_MC_MD:   cal.mc_md   <= cfg_wdata;
        bpc_pkg::REG_OSS:     cal.oss     <= cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  // Stored raw temperature.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_t <= '0;
    end else if (in_acc && (in_data.kind == bpc_pkg::KIND_TEMP)) begin
      last_t <= in_data.raw_value[15:0];
    end
  end

  bpc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (core_start),
    .raw       (in_data.raw_value),
    .last_t    (last_t),
    .cal       (cal),
    .res_take  (res_take),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res;
    end
  end

  `BPC_ASSERT(a_fault_zero, out_valid && out_data.div_fault |-> out_data.pressure_pa == '0, "fault with nonzero pressure")
  `BPC_ASSERT(a_temp_idle, in_acc && (in_data.kind == bpc_pkg::KIND_TEMP) |=> !in_stall, "temperature transaction made the block busy")
  `BPC_ASSERT(a_load_src, $rose(out_valid) |-> $past(res_valid), "result appeared without a finished computation")
  `BPC_ASSERT_ALWAYS(a_reset_idle, $past(rst) && !rst |-> !in_stall && !out_valid, "block not idle after reset")

endmodule
`default_nettype wire

// File: rtl/bpc_div.sv
// Bit-serial restoring divider, 32-bit unsigned, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bpc_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] qr;
  logic [31:0] dvs;
  logic [32:0] trial;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign trial = {rem, qr[31]} - {1'b0, dvs};
  assign quotient = qr;

  // Iteration control and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == 5'd31);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        qr   <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        if (trial[32]) begin
          rem <= {rem[30:0], qr[31]};
          qr  <= {qr[30:0], 1'b0};
        end else begin
          rem <= trial[31:0];
          qr  <= {qr[30:0], 1'b1};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/bpc_seq.sv
// Compensation sequencer around one shared 32x32 multiplier and the serial divider.
`timescale 1ns / 1ps
`default_nettype none
module bpc_seq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [23:0]   raw,
  input  wire logic [15:0]   last_t,
  input  wire bpc_pkg::cal_t cal,
  input  wire logic          res_take,
  output logic               busy,
  output logic               res_valid,
  output bpc_pkg::out_t      res
);

  bpc_pkg::state_t state, state_next;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  logic [31:0] ma, mb, mres;
  logic [63:0] prod;
  logic [31:0] up, x1r, b6r, b6sq, t1, b3r, b4r, pr;
  logic        qneg, bsh;
  logic [31:0] x1_t, den, mcs, x3_a3, b3_c, x3_a4, b4_c, pf;
  logic        div_start, div_done;
  logic [31:0] div_a, div_b, div_q, x2_d;
  logic [3:0]  up_sh;

  // Calibration fields.
  assign ac1 = bpc_pkg::sx16(cal.ac1_ac2[31:16]);
  assign ac2 = bpc_pkg::sx16(cal.ac1_ac2[15:0]);
  assign ac3 = bpc_pkg::sx16(cal.ac3_ac4[31:16]);
  assign ac4 = {16'b0, cal.ac3_ac4[15:0]};
  assign ac5 = {16'b0, cal.ac5_ac6[31:16]};
  assign ac6 = {16'b0, cal.ac5_ac6[15:0]};
  assign b1  = bpc_pkg::sx16(cal.b1_b2[31:16]);
  assign b2  = bpc_pkg::sx16(cal.b1_b2[15:0]);
  assign mc  = bpc_pkg::sx16(cal.mc_md[31:16]);
  assign md  = bpc_pkg::sx16(cal.mc_md[15:0]);

  // Intermediate terms taken from the registered product.
  assign up_sh = 4'd8 - {2'b0, cal.oss};
  assign x1_t  = bpc_pkg::asr(mres, 5'd15);
  assign den   = x1_t + md;
  assign mcs   = mc << 11;
  assign x3_a3 = t1 + bpc_pkg::asr(mres, 5'd11);
  assign b3_c  = bpc_pkg::asr((((ac1 << 2) + x3_a3) << cal.oss) + 32'd2, 5'd2);
  assign x3_a4 = bpc_pkg::asr(t1 + bpc_pkg::asr(mres, 5'd16) + 32'd2, 5'd2);
  assign b4_c  = mres >> 15;
  assign pf    = pr + bpc_pkg::asr(t1 + bpc_pkg::asr(mres, 5'd16) + bpc_pkg::C_K3, 5'd4);
  assign x2_d  = qneg ? (32'd0 - div_q) : div_q;

  // Shared multiplier operand selection.
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      bpc_pkg::ST_MUL_T: begin
        ma = {16'b0, last_t} - ac6;
        mb = ac5;
      end
      bpc_pkg::ST_MUL_SQ: begin
        ma = b6r;
        mb = b6r;
      end
      bpc_pkg::ST_MUL_B2: begin
        ma = b2;
        mb = bpc_pkg::asr(mres, 5'd12);
      end
      bpc_pkg::ST_MUL_A2: begin
        ma = ac2;
        mb = b6r;
      end
      bpc_pkg::ST_MUL_A3: begin
        ma = ac3;
        mb = b6r;
      end
      bpc_pkg::ST_MUL_B1: begin
        ma = b1;
        mb = b6sq;
      end
      bpc_pkg::ST_MUL_A4: begin
        ma = ac4;
        mb = x3_a4 + bpc_pkg::C_B4_RND;
      end
      bpc_pkg::ST_MUL_B7: begin
        ma = up - b3r;
        mb = bpc_pkg::C_B7_K >> cal.oss;
      end
      bpc_pkg::ST_MUL_PP: begin
        ma = bpc_pkg::asr(pr, 5'd8);
        mb = bpc_pkg::asr(pr, 5'd8);
      end
      bpc_pkg::ST_MUL_K1: begin
        ma = mres;
        mb = bpc_pkg::C_K1;
      end
      bpc_pkg::ST_MUL_K2: begin
        ma = bpc_pkg::C_K2;
        mb = pr;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;

  // Divider operands: signed temperature division or unsigned pressure division.
  always_comb begin
    if (state == bpc_pkg::ST_CHK_B7) begin
      div_a = mres[31] ? mres : (mres << 1);
      div_b = b4r;
    end else begin
      div_a = mcs[31] ? (32'd0 - mcs) : mcs;
      div_b = den[31] ? (32'd0 - den) : den;
    end
  end

  bpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      bpc_pkg::ST_IDLE:    if (start) state_next = bpc_pkg::ST_MUL_T;
      bpc_pkg::ST_MUL_T:   state_next = bpc_pkg::ST_CHK_DEN;
      bpc_pkg::ST_CHK_DEN: begin
        state_next = (den == '0) ? bpc_pkg::ST_DONE : bpc_pkg::ST_WAIT_D1;
      end
      bpc_pkg::ST_WAIT_D1: if (div_done) state_next = bpc_pkg::ST_MUL_SQ;
      bpc_pkg::ST_MUL_SQ:  state_next = bpc_pkg::ST_MUL_B2;
      bpc_pkg::ST_MUL_B2:  state_next = bpc_pkg::ST_MUL_A2;
      bpc_pkg::ST_MUL_A2:  state_next = bpc_pkg::ST_MUL_A3;
      bpc_pkg::ST_MUL_A3:  state_next = bpc_pkg::ST_MUL_B1;
      bpc_pkg::ST_MUL_B1:  state_next = bpc_pkg::ST_MUL_A4;
      bpc_pkg::ST_MUL_A4:  state_next = bpc_pkg::ST_MUL_B7;
      bpc_pkg::ST_MUL_B7: begin
        state_next = (b4_c == '0) ? bpc_pkg::ST_DONE : bpc_pkg::ST_CHK_B7;
      end
      bpc_pkg::ST_CHK_B7:  state_next = bpc_pkg::ST_WAIT_D2;
      bpc_pkg::ST_WAIT_D2: if (div_done) state_next = bpc_pkg::ST_MUL_PP;
      bpc_pkg::ST_MUL_PP:  state_next = bpc_pkg::ST_MUL_K1;
      bpc_pkg::ST_MUL_K1:  state_next = bpc_pkg::ST_MUL_K2;
      bpc_pkg::ST_MUL_K2:  state_next = bpc_pkg::ST_FIN;
      bpc_pkg::ST_FIN:     state_next = bpc_pkg::ST_DONE;
      bpc_pkg::ST_DONE:    if (res_take) state_next = bpc_pkg::ST_IDLE;
      default:             state_next = bpc_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    busy      = (state != bpc_pkg::ST_IDLE);
    res_valid = (state == bpc_pkg::ST_DONE);
    div_start = ((state == bpc_pkg::ST_CHK_DEN) && (den != '0)) ||
                (state == bpc_pkg::ST_CHK_B7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers; each state consumes the previous product.
  always_ff @(posedge clk) begin
    mres <= prod[31:0];
    case (state)
      bpc_pkg::ST_IDLE: begin
        up <= {8'b0, raw >> up_sh};
      end
      bpc_pkg::ST_CHK_DEN: begin
        x1r  <= x1_t;
        qneg <= mcs[31] ^ den[31];
        res  <= '{pressure_pa: '0, div_fault: 1'b1};
      end
      bpc_pkg::ST_WAIT_D1: begin
        b6r <= x1r + x2_d - bpc_pkg::C_B6_OFS;
      end
      bpc_pkg::ST_MUL_B2: begin
        b6sq <= bpc_pkg::asr(mres, 5'd12);
      end
      bpc_pkg::ST_MUL_A2: begin
        t1 <= bpc_pkg::asr(mres, 5'd11);
      end
      bpc_pkg::ST_MUL_A3: begin
        b3r <= b3_c;
      end
      bpc_pkg::ST_MUL_B1: begin
        t1 <= bpc_pkg::asr(mres, 5'd13);
      end
      bpc_pkg::ST_MUL_B7: begin
        b4r <= b4_c;
        res <= '{pressure_pa: '0, div_fault: 1'b1};
      end
      bpc_pkg::ST_CHK_B7: begin
        bsh <= mres[31];
      end
      bpc_pkg::ST_WAIT_D2: begin
        pr <= bsh ? (div_q << 1) : div_q;
      end
      bpc_pkg::ST_MUL_K2: begin
        t1 <= bpc_pkg::asr(mres, 5'd16);
      end
      bpc_pkg::ST_FIN: begin
        res.div_fault <= 1'b0;
        if (pf[31]) begin
          res.pressure_pa <= '0;
        end else if (pf > bpc_pkg::C_P_MAX) begin
          res.pressure_pa <= bpc_pkg::C_P_MAX[17:0];
        end else begin
          res.pressure_pa <= pf[17:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire
